@@ src/rme_pkg.sv @@
// rme_pkg: shared constants and types for the rotation matrix to euler angles block
// no dependencies
package rme_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int TableLen           = 24;
   localparam int DataW              = 16;
   localparam int AngleW             = 16;
   localparam int ThreshW            = 14;
   localparam int XyW                = 28;
   localparam int ZW                 = 28;
   localparam int ProdW              = 60;

   localparam logic signed [ZW-1:0]    HalfPiZ = 28'sd26353589;
   localparam logic signed [31:0]      InvGain = 32'sd652032874;
   localparam logic signed [AngleW-1:0] PiQ13  = 16'sd25736;

   typedef struct packed {
      logic signed [XyW-1:0] x;
      logic signed [XyW-1:0] y;
      logic signed [ZW-1:0]  z;
   } vec_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ZW-1:0] r;
      unique case (idx)
         5'd0:  r = 28'sd13176795;
         5'd1:  r = 28'sd7778716;
         5'd2:  r = 28'sd4110060;
         5'd3:  r = 28'sd2086331;
         5'd4:  r = 28'sd1047214;
         5'd5:  r = 28'sd524117;
         5'd6:  r = 28'sd262123;
         5'd7:  r = 28'sd131069;
         5'd8:  r = 28'sd65536;
         5'd9:  r = 28'sd32768;
         5'd10: r = 28'sd16384;
         5'd11: r = 28'sd8192;
         5'd12: r = 28'sd4096;
         5'd13: r = 28'sd2048;
         5'd14: r = 28'sd1024;
         5'd15: r = 28'sd512;
         5'd16: r = 28'sd256;
         5'd17: r = 28'sd128;
         5'd18: r = 28'sd64;
         5'd19: r = 28'sd32;
         5'd20: r = 28'sd16;
         5'd21: r = 28'sd8;
         5'd22: r = 28'sd4;
         5'd23: r = 28'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   // pre-rotation into the right half plane
   function automatic vec_type cordic_pre(input logic signed [XyW-1:0] x,
                                          input logic signed [XyW-1:0] y);
      vec_type v;
      v.x = x;
      v.y = y;
      v.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            v.x = y;
            v.y = -x;
            v.z = HalfPiZ;
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -HalfPiZ;
         end
      end
      return v;
   endfunction

   function automatic vec_type cordic_step(input vec_type v, input logic [4:0] i);
      vec_type r;
      logic signed [XyW-1:0] dx;
      logic signed [XyW-1:0] dy;
      dx = v.y >>> i;
      dy = v.x >>> i;
      if (v.y >= 0) begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.z = v.z + atan_entry(i);
      end else begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.z = v.z - atan_entry(i);
      end
      return r;
   endfunction

   function automatic logic signed [AngleW-1:0] to_angle(input logic signed [ZW-1:0] z);
      logic signed [ZW-1:0] a;
      a = (z + ZW'(1024)) >>> 11;
      if (a > ZW'(PiQ13)) a = ZW'(PiQ13);
      if (a < -ZW'(PiQ13)) a = -ZW'(PiQ13);
      return a[AngleW-1:0];
   endfunction

endpackage

@@ src/rme_cordic.sv @@
// rme_cordic: pipelined vectoring cordic, one micro-rotation per stage
// depends on rme_pkg
module rme_cordic
   import rme_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic signed [XyW-1:0] x_in,
   input  logic signed [XyW-1:0] y_in,
   output logic signed [XyW-1:0] x_out,
   output logic signed [ZW-1:0]  z_out
);

   vec_type stage_ff [CORDIC_STEPS+1];
   logic    zero_ff  [CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= cordic_pre(x_in, y_in);
         zero_ff[0]  <= (x_in == '0) && (y_in == '0);
      end
   end

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[s+1] <= cordic_step(stage_ff[s], 5'(s));
            zero_ff[s+1]  <= zero_ff[s];
         end
      end
   end

   assign x_out = zero_ff[CORDIC_STEPS] ? '0 : stage_ff[CORDIC_STEPS].x;
   assign z_out = zero_ff[CORDIC_STEPS] ? '0 : stage_ff[CORDIC_STEPS].z;

endmodule

@@ src/rotation_matrix_to_euler_angles.sv @@
// channel | ports                                   | accepted when
// req     | req_valid req_stall req_m00..req_m12    | req_valid && !req_stall
// rsp     | rsp_valid rsp_stall rsp_roll_angle..    | rsp_valid && !rsp_stall
// csr     | csr_write csr_data                      | csr_write
// one request per cycle while req_stall is low; a request passes through two cordic
// pipelines in series (sy then pitch) plus the gain multiply and output stages
// reset clears valid bits and sets the threshold to 1
// a stall freezes the whole pipeline; req_stall follows rsp_stall when the output is full
// top level: rotation matrix to euler angles (zyx); depends on rme_pkg and rme_cordic
module rotation_matrix_to_euler_angles
   import rme_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DataW-1:0]  req_m00,
   input  logic signed [DataW-1:0]  req_m10,
   input  logic signed [DataW-1:0]  req_m20,
   input  logic signed [DataW-1:0]  req_m21,
   input  logic signed [DataW-1:0]  req_m22,
   input  logic signed [DataW-1:0]  req_m11,
   input  logic signed [DataW-1:0]  req_m12,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [AngleW-1:0] rsp_roll_angle,
   output logic signed [AngleW-1:0] rsp_pitch_angle,
   output logic signed [AngleW-1:0] rsp_yaw_angle,
   output logic                     rsp_is_singular,
   input  logic                     csr_write,
   input  logic [ThreshW-1:0]       csr_data
);

   localparam int Lat1 = CORDIC_STEPS + 1;   // first cordic
   localparam int Lat  = 2 * CORDIC_STEPS + 4;

   logic advance;
   logic [ThreshW-1:0] thresh_ff;
   logic valid_ff [Lat+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) thresh_ff <= ThreshW'(1);
      else if (csr_write) thresh_ff <= csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Lat; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k <= Lat; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end
   assign rsp_valid = valid_ff[Lat];

   // matrix elements in q6.22
   function automatic logic signed [XyW-1:0] q22(input logic signed [DataW-1:0] v);
      return {{(XyW-DataW-8){v[DataW-1]}}, v, 8'd0};
   endfunction

   // first wave: yaw/sy cordic plus both roll candidates
   logic signed [XyW-1:0] sy_x;
   logic signed [ZW-1:0]  yaw_z, rolla_z, rollb_z;
   logic signed [XyW-1:0] unused_a, unused_b, unused_c;

   rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
      .clock(clock), .advance(advance), .x_in(q22(req_m00)), .y_in(q22(req_m10)),
      .x_out(sy_x), .z_out(yaw_z));
   rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_rolla (
      .clock(clock), .advance(advance), .x_in(q22(req_m22)), .y_in(q22(req_m21)),
      .x_out(unused_a), .z_out(rolla_z));
   rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_rollb (
      .clock(clock), .advance(advance), .x_in(q22(req_m11)), .y_in(-q22(req_m12)),
      .x_out(unused_b), .z_out(rollb_z));

   logic signed [XyW-1:0] m20_ff [Lat1];
   always_ff @(posedge clock) begin
      if (advance) begin
         m20_ff[0] <= -q22(req_m20);
         for (int k = 1; k < Lat1; k++) m20_ff[k] <= m20_ff[k-1];
      end
   end

   // gain correction: multiply, then round and clamp
   logic signed [ProdW-1:0] prod_ff;
   logic signed [XyW-1:0]   ny_ff, sy_ff, ny2_ff;
   logic signed [ZW-1:0]    yaw1_ff, ra1_ff, rb1_ff, yaw2_ff, ra2_ff, rb2_ff;
   logic signed [ZW-1:0]    yaw3_ff, ra3_ff, rb3_ff;
   logic signed [ProdW-1:0] sy_round;
   logic signed [XyW-1:0]   sy14_full;
   logic                    sing_ff;

   assign sy_round  = (prod_ff + (ProdW'(1) <<< 29)) >>> 30;
   assign sy14_full = (sy_round < 0) ? '0 : sy_round[XyW-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= ProdW'(sy_x) * ProdW'(InvGain);
         ny_ff   <= m20_ff[Lat1-1];
         yaw1_ff <= yaw_z;
         ra1_ff  <= rolla_z;
         rb1_ff  <= rollb_z;
         sy_ff   <= sy14_full;
         ny2_ff  <= ny_ff;
         yaw2_ff <= yaw1_ff;
         ra2_ff  <= ra1_ff;
         rb2_ff  <= rb1_ff;
      end
   end

   logic signed [XyW-1:0] sy14;
   assign sy14 = (sy_ff + XyW'(128)) >>> 8;

   // singular flag from the threshold compare; roll and yaw candidates delayed to line up with sing_ff
   always_ff @(posedge clock) begin
      if (advance) begin
         sing_ff <= sy14 < $signed({1'b0, thresh_ff});
         yaw3_ff <= yaw2_ff;
         ra3_ff  <= ra2_ff;
         rb3_ff  <= rb2_ff;
      end
   end

   // pitch cordic
   logic signed [ZW-1:0] pitch_z;
   rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock(clock), .advance(advance), .x_in(sy_ff), .y_in(ny2_ff),
      .x_out(unused_c), .z_out(pitch_z));

   localparam int Dly = CORDIC_STEPS;
   logic signed [ZW-1:0] rollsel_ff [Dly];
   logic signed [ZW-1:0] yawsel_ff  [Dly];
   logic                 sd_ff      [Dly];
   always_ff @(posedge clock) begin
      if (advance) begin
         rollsel_ff[0] <= sing_ff ? rb3_ff : ra3_ff;
         yawsel_ff[0]  <= sing_ff ? '0 : yaw3_ff;
         sd_ff[0]      <= sing_ff;
         for (int k = 1; k < Dly; k++) begin
            rollsel_ff[k] <= rollsel_ff[k-1];
            yawsel_ff[k]  <= yawsel_ff[k-1];
            sd_ff[k]      <= sd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_roll_angle  <= to_angle(rollsel_ff[Dly-1]);
         rsp_pitch_angle <= to_angle(pitch_z);
         rsp_yaw_angle   <= to_angle(yawsel_ff[Dly-1]);
         rsp_is_singular <= sd_ff[Dly-1];
      end
   end

endmodule

@@ src/rme_checker.sv @@
// rme_checker: port-level assertions for rotation_matrix_to_euler_angles
// depends on rme_pkg; bound to the top level
module rme_checker
   import rme_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [AngleW-1:0] rsp_roll_angle,
   input logic signed [AngleW-1:0] rsp_pitch_angle,
   input logic signed [AngleW-1:0] rsp_yaw_angle,
   input logic                     rsp_is_singular
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_roll_angle))
      else $error("stalled result changed");

   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output stall");

   a_sing_yaw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_singular |-> rsp_yaw_angle == '0)
      else $error("yaw nonzero when singular");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_angle <= PiQ13 && rsp_pitch_angle >= -PiQ13)
      else $error("pitch out of range");

endmodule

bind rotation_matrix_to_euler_angles rme_checker u_rme_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_roll_angle(rsp_roll_angle),
   .rsp_pitch_angle(rsp_pitch_angle), .rsp_yaw_angle(rsp_yaw_angle),
   .rsp_is_singular(rsp_is_singular));
